### design/fys_pkg.sv
package fys_pkg;

  localparam int MAX_LEN = 16;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int CNT_W   = IDX_W + 1;
  localparam int CFG_W   = 5;
  localparam int VAL_W   = 32;
  localparam int DRAW_W  = 16;
  localparam int STEP_W  = $clog2(DRAW_W + 1);

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_DRAW = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_RD_A,
    ST_RD_B,
    ST_WR_A,
    ST_WR_B,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_e;

  typedef enum logic [1:0] {
    RD_N1,
    RD_R,
    RD_K
  } rd_sel_e;

  typedef struct packed {
    logic    load_en;
    logic    draw_en;
    rd_sel_e rd_sel;
    logic    tmp_load;
    logic    wr_a;
    logic    wr_b;
    logic    emit_push;
  } cmd_t;

  typedef struct packed {
    logic load_emits;
    logic draw_ok;
    logic mod_done;
    logic last_swap;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage

### design/fys_in_if.sv
interface fys_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic signed [fys_pkg::VAL_W-1:0]     element_value;
  logic        [fys_pkg::DRAW_W-1:0]    random_draw;

  modport source (output valid, output action, output element_value,
                  output random_draw, input ready);
  modport sink (input valid, input action, input element_value,
                input random_draw, output ready);
endinterface

### design/fys_out_if.sv
interface fys_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fys_pkg::VAL_W-1:0]     out_value;
  logic        [fys_pkg::IDX_W-1:0]     out_position;
  logic                                 last_of_run;

  modport source (output valid, output out_value, output out_position,
                  output last_of_run, input ready);
  modport sink (input valid, input out_value, input out_position,
                input last_of_run, output ready);
endinterface

### design/fys_mod.sv
module fys_mod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fys_pkg::DRAW_W-1:0]  dividend_i,
  input  logic [fys_pkg::CNT_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [fys_pkg::IDX_W-1:0]   rem_o
);
  import fys_pkg::*;

  logic              busy_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DRAW_W-1:0] dvd_q;
  logic [CNT_W-1:0]  dvs_q;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W:0]    trial;

  // One restoring step per cycle, most significant dividend bit first.
  always_comb begin
    trial = {rem_q, dvd_q[DRAW_W-1]};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = CNT_W'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = CNT_W'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_W'(DRAW_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DRAW_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[IDX_W-1:0];

endmodule

### design/fys_ctrl.sv
module fys_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           action_i,
  input  fys_pkg::stat_t stat_i,
  output logic           in_ready_o,
  output fys_pkg::cmd_t  cmd_o,
  output fys_pkg::state_e state_o
);
  import fys_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (action_i == ACT_LOAD) begin
            if (stat_i.load_emits) state_d = ST_EMIT_RD;
          end else if (stat_i.draw_ok) begin
            state_d = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (stat_i.mod_done) state_d = ST_RD_A;
      end
      ST_RD_A: state_d = ST_RD_B;
      ST_RD_B: state_d = ST_WR_A;
      ST_WR_A: state_d = ST_WR_B;
      ST_WR_B: begin
        state_d = stat_i.last_swap ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: state_d = ST_EMIT_WR;
      ST_EMIT_WR: begin
        if (stat_i.out_free) begin
          state_d = stat_i.emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    cmd_o.rd_sel    = RD_K;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_en = in_valid_i && (action_i == ACT_LOAD);
        cmd_o.draw_en = in_valid_i && (action_i == ACT_DRAW);
      end
      ST_RD_A: cmd_o.rd_sel = RD_N1;
      ST_RD_B: begin
        cmd_o.rd_sel   = RD_R;
        cmd_o.tmp_load = 1'b1;
      end
      ST_WR_A:    cmd_o.wr_a = 1'b1;
      ST_WR_B:    cmd_o.wr_b = 1'b1;
      ST_EMIT_WR: cmd_o.emit_push = stat_i.out_free;
      default: begin
        cmd_o.rd_sel = RD_K;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

### design/fys_datapath.sv
module fys_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fys_pkg::cmd_t                     cmd_i,
  output fys_pkg::stat_t                    stat_o,
  input  logic signed [fys_pkg::VAL_W-1:0]  element_value_i,
  input  logic        [fys_pkg::DRAW_W-1:0] random_draw_i,
  input  logic                              cfg_we_i,
  input  logic        [fys_pkg::CFG_W-1:0]  cfg_wdata_i,
  fys_out_if.source                         out_o
);
  import fys_pkg::*;

  logic signed [VAL_W-1:0] mem [MAX_LEN];
  logic signed [VAL_W-1:0] rdata_q, tmp_q, wdata;
  logic        [IDX_W-1:0] raddr, waddr;
  logic                    we;

  logic [CFG_W-1:0] list_length_q;
  logic [CNT_W-1:0] load_pos_q, n_q, run_len_q;
  logic             shuffle_q;
  logic [IDX_W-1:0] k_q;

  logic [CNT_W-1:0] len, pos, pos_next;
  logic             mod_start, mod_done;
  logic [IDX_W-1:0] r;

  logic                    out_valid_q;
  logic signed [VAL_W-1:0] out_value_q;
  logic [IDX_W-1:0]        out_position_q;
  logic                    last_q;

  // Effective list length: zero counts as one, oversize clamps to the store depth.
  always_comb begin
    if (list_length_q == '0) begin
      len = CNT_W'(1);
    end else if (int'(list_length_q) > MAX_LEN) begin
      len = CNT_W'(MAX_LEN);
    end else begin
      len = CNT_W'(list_length_q);
    end
    pos      = (shuffle_q || load_pos_q >= len) ? '0 : load_pos_q;
    pos_next = pos + CNT_W'(1);
  end

  always_comb begin
    stat_o.load_emits = (len == CNT_W'(1));
    stat_o.draw_ok    = shuffle_q && (n_q >= CNT_W'(2)) && (int'(n_q) <= MAX_LEN);
    stat_o.mod_done   = mod_done;
    stat_o.last_swap  = (n_q <= CNT_W'(2));
    stat_o.emit_last  = ((CNT_W'(k_q) + CNT_W'(1)) == run_len_q);
    stat_o.out_free   = !out_valid_q || out_o.ready;
  end

  assign mod_start = cmd_i.draw_en && stat_o.draw_ok;

  fys_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (random_draw_i),
    .divisor_i  (n_q),
    .done_o     (mod_done),
    .rem_o      (r)
  );

  always_comb begin
    case (cmd_i.rd_sel)
      RD_N1:   raddr = IDX_W'(n_q - CNT_W'(1));
      RD_R:    raddr = r;
      default: raddr = k_q;
    endcase
    we    = 1'b0;
    waddr = pos[IDX_W-1:0];
    wdata = element_value_i;
    if (cmd_i.load_en) begin
      we = 1'b1;
    end else if (cmd_i.wr_a) begin
      we    = 1'b1;
      waddr = IDX_W'(n_q - CNT_W'(1));
      wdata = rdata_q;
    end else if (cmd_i.wr_b) begin
      we    = 1'b1;
      waddr = r;
      wdata = tmp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
    if (cmd_i.tmp_load) begin
      tmp_q <= rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_length_q <= CFG_W'(10);
      load_pos_q    <= '0;
      n_q           <= '0;
      run_len_q     <= '0;
      shuffle_q     <= 1'b0;
      k_q           <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        list_length_q <= cfg_wdata_i;
      end
      if (cmd_i.load_en) begin
        if (pos_next >= len) begin
          load_pos_q <= '0;
          run_len_q  <= len;
          if (len == CNT_W'(1)) begin
            shuffle_q <= 1'b0;
            n_q       <= '0;
          end else begin
            shuffle_q <= 1'b1;
            n_q       <= len;
          end
        end else begin
          load_pos_q <= pos_next;
          shuffle_q  <= 1'b0;
          n_q        <= '0;
        end
      end else if (cmd_i.draw_en && !stat_o.draw_ok) begin
        shuffle_q <= 1'b0;
        n_q       <= '0;
      end else if (cmd_i.wr_b) begin
        if (stat_o.last_swap) begin
          shuffle_q  <= 1'b0;
          n_q        <= '0;
          load_pos_q <= '0;
        end else begin
          n_q <= n_q - CNT_W'(1);
        end
      end
      if (cmd_i.emit_push) begin
        out_valid_q <= 1'b1;
        k_q         <= stat_o.emit_last ? '0 : k_q + IDX_W'(1);
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_push) begin
      out_value_q    <= rdata_q;
      out_position_q <= k_q;
      last_q         <= stat_o.emit_last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_value    = out_value_q;
  assign out_o.out_position = out_position_q;
  assign out_o.last_of_run  = last_q;

endmodule

### design/fisher_yates_shuffler.sv
// Loads list_length elements (load transactions), then shuffles them in place
// with Fisher-Yates, one draw transaction per swap, and emits the shuffled list
// as one run of results with last_of_run on the final one. A draw's remainder
// draw mod n comes from a restoring divider that retires one bit per cycle
// and hands over the result when done; the swap then steps through four states
// (read, read, write, write) on the element memory, which has one read and one
// write port, and then the block returns to idle. The draw that finishes the
// shuffle, or the load that completes a one-element list, is followed by the
// run, each result a memory read, then a push into the output register that
// waits while the sink stalls. No input is taken while a draw or a run is in
// progress; the last result may still wait in the output register while the
// next transaction is taken.
module fisher_yates_shuffler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  fys_in_if.sink                           in_i,
  fys_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [fys_pkg::CFG_W-1:0]        cfg_wdata_i
);
  import fys_pkg::*;

  cmd_t   cmd;
  stat_t  stat;
  state_e state;
  logic   in_ready;

  fys_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .action_i   (in_i.action),
    .stat_i     (stat),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  fys_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .element_value_i (in_i.element_value),
    .random_draw_i   (in_i.random_draw),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_o           (out_o)
  );

  assign in_i.ready = in_ready;

  // An accepted draw that starts the divider blocks input until the swap ends.
  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready && in_i.action == ACT_DRAW && stat.draw_ok) |=> !in_ready)
    else $error("input taken while a draw is in progress");

  // The divider only finishes while the controller waits for it.
  a_mod_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.mod_done |-> (state == ST_MOD))
    else $error("remainder finished outside the wait state");

  // A result is pushed only into a free output register.
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_push |-> stat.out_free)
    else $error("result pushed over a waiting result");

  // A one-element list goes straight to emission.
  a_single_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready && in_i.action == ACT_LOAD && stat.load_emits)
      |=> (state == ST_EMIT_RD))
    else $error("one-element list not emitted");

endmodule

### tb/sv/tb_fisher_yates_shuffler.sv
module tb_fisher_yates_shuffler;
  import fys_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int SETTLE_CYCLES  = 64;
  localparam int TIMEOUT_CYCLES = 800000;
  localparam int ITEMS_PER_PHASE = 105;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        position;
    logic                    last;
  } shuffled_elem_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  fys_in_if  stim_if ();
  fys_out_if res_if ();

  fisher_yates_shuffler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (stim_if),
    .out_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Shadow copy of the shuffler state.
  logic signed [VAL_W-1:0] elem_store [MAX_LEN];
  logic [CNT_W-1:0]        fill_slot   = '0;
  logic [CNT_W-1:0]        draws_left  = '0;
  logic                    shuffling   = 1'b0;
  logic [CNT_W-1:0]        run_length  = '0;
  logic [CFG_W-1:0]        length_reg  = 5'd10;

  shuffled_elem_t shuffled_queue [$];
  int error_count   = 0;
  int counted_items = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int idle_by_phase  [4] = '{0, 73, 0, 34};
  int stall_by_phase [4] = '{0, 0, 73, 34};

  function automatic logic [CNT_W-1:0] active_length();
    if (length_reg == 0) return CNT_W'(1);
    if (length_reg > MAX_LEN) return CNT_W'(MAX_LEN);
    return length_reg;
  endfunction

  task automatic queue_run(logic [CNT_W-1:0] len);
    for (int k = 0; k < len; k++) begin
      shuffled_queue.push_back('{elem_store[k], k[IDX_W-1:0], (k + 1 == len)});
    end
  endtask

  task automatic predict_shuffle(action_e act, logic signed [VAL_W-1:0] val,
                                 logic [DRAW_W-1:0] draw);
    logic [CNT_W-1:0]        len;
    logic [CNT_W-1:0]        n;
    logic [CNT_W-1:0]        r;
    logic signed [VAL_W-1:0] tmp;
    if (act == ACT_LOAD || shuffling) counted_items++;
    if (act == ACT_LOAD) begin
      len = active_length();
      if (shuffling) begin
        shuffling  = 1'b0;
        draws_left = '0;
        fill_slot  = '0;
      end
      if (fill_slot >= len) fill_slot = '0;
      elem_store[fill_slot[IDX_W-1:0]] = val;
      fill_slot++;
      if (fill_slot >= len) begin
        fill_slot = '0;
        if (len == 1) begin
          queue_run(CNT_W'(1));
        end else begin
          shuffling  = 1'b1;
          draws_left = len;
          run_length = len;
        end
      end
    end else if (!shuffling || draws_left < 2 || draws_left > MAX_LEN) begin
      shuffling  = 1'b0;
      draws_left = '0;
    end else begin
      r   = CNT_W'(draw % draws_left);
      n   = draws_left - CNT_W'(1);
      tmp = elem_store[n[IDX_W-1:0]];
      elem_store[n[IDX_W-1:0]] = elem_store[r[IDX_W-1:0]];
      elem_store[r[IDX_W-1:0]] = tmp;
      draws_left = n;
      if (n <= 1) begin
        shuffling  = 1'b0;
        draws_left = '0;
        fill_slot  = '0;
        queue_run(run_length);
      end
    end
  endtask

  // Valid stays high between back-to-back transactions; it is only lowered
  // while idling and in settle_block.
  task automatic send_item(action_e act, logic signed [VAL_W-1:0] val,
                           logic [DRAW_W-1:0] draw);
    while ($urandom_range(99) < send_idle_pct) begin
      stim_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    stim_if.valid         <= 1'b1;
    stim_if.action        <= act;
    stim_if.element_value <= val;
    stim_if.random_draw   <= draw;
    do @(posedge clk_i); while (!stim_if.ready);
    predict_shuffle(act, val, draw);
  endtask

  task automatic send_load(logic signed [VAL_W-1:0] val);
    send_item(ACT_LOAD, val, DRAW_W'($urandom));
  endtask

  task automatic send_draw(logic [DRAW_W-1:0] draw);
    send_item(ACT_DRAW, $urandom, draw);
  endtask

  // A draw that completes no run still keeps the block busy for a while.
  task automatic settle_block();
    stim_if.valid <= 1'b0;
    while (shuffled_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_len(logic [CFG_W-1:0] len);
    settle_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    length_reg   = len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_length();
    case ($urandom_range(9))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'd17;
      4: return 5'd31;
      default: return CFG_W'($urandom_range(2, 8));
    endcase
  endfunction

  task automatic test_default_length();
    logic signed [VAL_W-1:0] extreme_vals [4];
    extreme_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1};
    for (int k = 0; k < 10; k++) send_load(k < 4 ? extreme_vals[k] : $urandom);
    send_draw(16'h0000);
    send_draw(16'hFFFF);
    for (int k = 0; k < 7; k++) send_draw(DRAW_W'($urandom_range(65535)));
  endtask

  task automatic test_single_element();
    write_len(5'd1);
    send_load($urandom);
    write_len(5'd0);
    send_load($urandom);
    send_load($urandom);
  endtask

  task automatic test_abandoned_shuffle();
    write_len(5'd2);
    send_load($urandom);
    send_load($urandom);
    send_load($urandom);
    send_load($urandom);
    send_draw(DRAW_W'($urandom_range(65535)));
  endtask

  task automatic test_length_lowered();
    write_len(5'd4);
    send_draw(DRAW_W'($urandom_range(65535)));
    send_load($urandom);
    send_load($urandom);
    write_len(5'd2);
    send_load($urandom);
    send_load($urandom);
    send_draw(DRAW_W'($urandom_range(65535)));
  endtask

  task automatic test_random_shuffles();
    int start_count;
    int pick;
    int loads_needed;
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = idle_by_phase[phase];
      recv_stall_pct = stall_by_phase[phase];
      start_count    = counted_items;
      while (counted_items - start_count < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 12) begin
          write_len(pick_length());
        end else if (pick < 80) begin
          if (!shuffling) begin
            loads_needed = (fill_slot >= active_length()) ? active_length()
                                                          : active_length() - fill_slot;
            repeat (loads_needed) send_load($urandom);
          end
          while (shuffling) begin
            // A length change in mid-shuffle must not affect the list at hand.
            if ($urandom_range(19) == 0) write_len(pick_length());
            send_draw(DRAW_W'($urandom_range(65535)));
          end
        end else if (pick < 88) begin
          repeat ($urandom_range(1, 3)) send_load($urandom);
        end else if (pick < 94) begin
          repeat ($urandom_range(1, 2)) send_draw(DRAW_W'($urandom_range(65535)));
        end else begin
          if (!shuffling) begin
            repeat (active_length()) send_load($urandom);
          end
          if (shuffling) begin
            repeat ($urandom_range(draws_left - 2)) send_draw(DRAW_W'($urandom_range(65535)));
            send_load($urandom);
          end
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    shuffled_elem_t got;
    shuffled_elem_t want;
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = '{res_if.out_value, res_if.out_position, res_if.last_of_run};
      if (shuffled_queue.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: value %0d position %0d last %0b",
                 $time, got.value, got.position, got.last);
      end else begin
        want = shuffled_queue.pop_front();
        if (got.value !== want.value || got.position !== want.position ||
            got.last !== want.last) begin
          error_count++;
          $display("%0t: mismatch: expected value %0d position %0d last %0b,",
                   $time, want.value, want.position, want.last,
                   " got value %0d position %0d last %0b",
                   got.value, got.position, got.last);
        end
      end
    end
  end

  initial begin
    stim_if.valid         <= 1'b0;
    stim_if.action        <= ACT_LOAD;
    stim_if.element_value <= '0;
    stim_if.random_draw   <= '0;
    cfg_we_i              <= 1'b0;
    cfg_wdata_i           <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_length();
    test_single_element();
    test_abandoned_shuffle();
    test_length_lowered();
    test_random_shuffles();
    settle_block();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### filelist.f
design/fys_pkg.sv
design/fys_in_if.sv
design/fys_out_if.sv
design/fys_mod.sv
design/fys_ctrl.sv
design/fys_datapath.sv
design/fisher_yates_shuffler.sv
tb/sv/tb_fisher_yates_shuffler.sv
